@@ sv/lfr_pkg.sv @@
// ----------------------------------------------------------------------------
// lfr_pkg
// Types and constants shared by the letter frequency ranker and its cells.
// ----------------------------------------------------------------------------
package lfr_pkg;

    localparam int ALPHABET_SIZE_DEF = 26;
    localparam int COUNT_WIDTH_DEF   = 16;
    localparam int TAG_W             = 5;
    localparam int LETTER_W          = 7;
    localparam int OUT_COUNT_W       = 16;
    localparam int MAX_COUNT_W       = 64;

    localparam logic       KIND_CHAR     = 1'b0;
    localparam logic       KIND_END      = 1'b1;
    localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z  = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z  = 8'h7a;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic [LETTER_W-1:0]    letter;
        logic [OUT_COUNT_W-1:0] count;
        logic                   last;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_COUNT,
        CELL_SWAP_EVEN,
        CELL_SWAP_ODD,
        CELL_SHIFT,
        CELL_CLEAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [TAG_W-1:0] idx;
    } t_cell_cmd;

endpackage

@@ sv/lfr_cell.sv @@
// ----------------------------------------------------------------------------
// lfr_cell
// One slot of the ranking chain: a letter counter and its tag, with a
// compare-exchange against either neighbor and a shift toward the head.
// ----------------------------------------------------------------------------
module lfr_cell #(
    parameter int IDX         = 0,
    parameter int NUM_CELLS   = lfr_pkg::ALPHABET_SIZE_DEF,
    parameter int COUNT_WIDTH = lfr_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lfr_pkg::t_cell_cmd             i_cmd,
    input  logic [COUNT_WIDTH-1:0]         i_left_cnt,
    input  logic [lfr_pkg::TAG_W-1:0]      i_left_tag,
    input  logic [COUNT_WIDTH-1:0]         i_right_cnt,
    input  logic [lfr_pkg::TAG_W-1:0]      i_right_tag,
    output logic [COUNT_WIDTH-1:0]         o_cnt,
    output logic [lfr_pkg::TAG_W-1:0]      o_tag
);
    import lfr_pkg::*;

    localparam bit IS_EVEN   = (IDX % 2) == 0;
    localparam bit HAS_LEFT  = IDX > 0;
    localparam bit HAS_RIGHT = (IDX + 1) < NUM_CELLS;
    localparam logic [TAG_W-1:0] MY_TAG = TAG_W'(IDX);

    logic [COUNT_WIDTH-1:0] r_cnt, n_cnt;
    logic [TAG_W-1:0]       r_tag, n_tag;
    logic                   w_take_right;
    logic                   w_take_left;
    logic                   w_left_role;
    logic                   w_right_role;

    always_comb begin
        w_left_role  = 1'b0;
        w_right_role = 1'b0;
        if (i_cmd.op == CELL_SWAP_EVEN) begin
            w_left_role  = IS_EVEN && HAS_RIGHT;
            w_right_role = !IS_EVEN && HAS_LEFT;
        end else if (i_cmd.op == CELL_SWAP_ODD) begin
            w_left_role  = !IS_EVEN && HAS_RIGHT;
            w_right_role = IS_EVEN && HAS_LEFT;
        end
        w_take_right = w_left_role && (r_cnt < i_right_cnt);
        w_take_left  = w_right_role && (i_left_cnt < r_cnt);
    end

    always_comb begin
        n_cnt = r_cnt;
        n_tag = r_tag;
        unique case (i_cmd.op)
            CELL_COUNT: begin
                if (i_cmd.idx == MY_TAG && r_cnt != '1) begin
                    n_cnt = r_cnt + COUNT_WIDTH'(1);
                end
            end
            CELL_SWAP_EVEN, CELL_SWAP_ODD: begin
                if (w_take_right) begin
                    n_cnt = i_right_cnt;
                    n_tag = i_right_tag;
                end else if (w_take_left) begin
                    n_cnt = i_left_cnt;
                    n_tag = i_left_tag;
                end
            end
            CELL_SHIFT: begin
                n_cnt = i_right_cnt;
                n_tag = i_right_tag;
            end
            CELL_CLEAR: begin
                n_cnt = '0;
                n_tag = MY_TAG;
            end
            default: begin
                n_cnt = r_cnt;
                n_tag = r_tag;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_tag <= MY_TAG;
        end else begin
            r_cnt <= n_cnt;
            r_tag <= n_tag;
        end
    end

    assign o_cnt = r_cnt;
    assign o_tag = r_tag;

endmodule

@@ sv/letter_frequency_ranker.sv @@
// ----------------------------------------------------------------------------
// letter_frequency_ranker
// Letter histogram over a character stream, ranked by count on an end item.
// ----------------------------------------------------------------------------
// Character items (kind 0) are taken one per cycle while busy is low; letters
// fold to lower case and bump their own saturating counter, other bytes are
// dropped. An end item raises busy, runs an odd-even transposition sort
// over the cell chain (ties keep alphabetical order), then shifts the chain
// toward the head, one letter per cycle: o_valid pulses once per nonzero
// letter, highest count first, with last set on the final one. The chain is
// then cleared and busy falls. Results are not held: the receiver must
// take each one in the cycle it is shown.
module letter_frequency_ranker #(
    parameter int ALPHABET_SIZE = lfr_pkg::ALPHABET_SIZE_DEF,
    parameter int COUNT_WIDTH   = lfr_pkg::COUNT_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  lfr_pkg::t_in_item  i_item,
    output logic               o_valid,
    output lfr_pkg::t_out_item o_item
);
    import lfr_pkg::*;

    localparam int PH_W = $clog2(ALPHABET_SIZE);
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(ALPHABET_SIZE - 1);

    t_state              r_state, n_state;
    logic [PH_W-1:0]     r_phase, n_phase;
    logic                r_valid, n_valid;
    t_out_item           r_item, n_item;
    t_cell_cmd           w_cmd;

    logic [COUNT_WIDTH-1:0] w_cnt [ALPHABET_SIZE];
    logic [TAG_W-1:0]       w_tag [ALPHABET_SIZE];

    logic                   w_accept;
    logic                   w_is_upper;
    logic                   w_is_lower;
    logic [7:0]             w_offset;
    logic [TAG_W-1:0]       w_idx;
    logic                   w_hit;
    logic [MAX_COUNT_W-1:0] w_head_ext;

    // letter decode
    always_comb begin
        w_is_upper = (i_item.char_code >= CHAR_UPPER_A) && (i_item.char_code <= CHAR_UPPER_Z);
        w_is_lower = (i_item.char_code >= CHAR_LOWER_A) && (i_item.char_code <= CHAR_LOWER_Z);
        w_offset   = w_is_upper ? (i_item.char_code - CHAR_UPPER_A)
                                : (i_item.char_code - CHAR_LOWER_A);
        w_idx      = w_offset[TAG_W-1:0];
        w_hit      = (w_is_upper || w_is_lower) && (int'(w_idx) < ALPHABET_SIZE);
    end

    assign w_accept   = start && !busy;
    assign w_head_ext = MAX_COUNT_W'(w_cnt[0]);

    // cell chain
    for (genvar g = 0; g < ALPHABET_SIZE; g++) begin : g_cell
        logic [COUNT_WIDTH-1:0] w_l_cnt, w_r_cnt;
        logic [TAG_W-1:0]       w_l_tag, w_r_tag;
        if (g > 0) begin : g_left
            assign w_l_cnt = w_cnt[g-1];
            assign w_l_tag = w_tag[g-1];
        end else begin : g_head
            assign w_l_cnt = '0;
            assign w_l_tag = '0;
        end
        if (g < ALPHABET_SIZE - 1) begin : g_right
            assign w_r_cnt = w_cnt[g+1];
            assign w_r_tag = w_tag[g+1];
        end else begin : g_tail
            assign w_r_cnt = '0;
            assign w_r_tag = '0;
        end
        lfr_cell #(
            .IDX         (g),
            .NUM_CELLS   (ALPHABET_SIZE),
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (w_cmd),
            .i_left_cnt  (w_l_cnt),
            .i_left_tag  (w_l_tag),
            .i_right_cnt (w_r_cnt),
            .i_right_tag (w_r_tag),
            .o_cnt       (w_cnt[g]),
            .o_tag       (w_tag[g])
        );
    end

    // control
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_valid     = 1'b0;
        n_item      = r_item;
        w_cmd.op    = CELL_HOLD;
        w_cmd.idx   = w_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_item.kind == KIND_END) begin
                        n_state = ST_SORT;
                        n_phase = '0;
                    end else if (w_hit) begin
                        w_cmd.op = CELL_COUNT;
                    end
                end
            end
            ST_SORT: begin
                w_cmd.op = r_phase[0] ? CELL_SWAP_ODD : CELL_SWAP_EVEN;
                n_phase  = r_phase + PH_W'(1);
                if (r_phase == PH_LAST) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_cnt[0] != '0) begin
                    w_cmd.op      = CELL_SHIFT;
                    n_valid       = 1'b1;
                    n_item.letter = LETTER_W'(CHAR_LOWER_A) + LETTER_W'(w_tag[0]);
                    n_item.count  = w_head_ext[OUT_COUNT_W-1:0];
                    n_item.last   = (w_cnt[1] == '0);
                end else begin
                    w_cmd.op = CELL_CLEAR;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign busy    = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_item  = r_item;

`ifndef NO_ASSERTIONS
    a_end_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.kind == KIND_END) |=> busy)
        else $error("end item did not start ranking");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_EMIT))
        else $error("result outside emission");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.last) |=> !o_valid)
        else $error("result after last");

    a_sort_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SORT && r_phase != PH_LAST) |=> (r_state == ST_SORT))
        else $error("sort ended early");
`endif

endmodule
